### src/rpt_pkg.sv
// rpt_pkg: types, codes and helpers shared by the rigid point transform pipeline.
// No dependencies; imported by every module under src.
package rpt_pkg;

    localparam int COEF_W  = 16;
    localparam int COORD_W = 32;
    localparam int OPND_W  = COORD_W + 1;
    localparam int PROD_W  = COEF_W + OPND_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_SH = 14;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_ROW     = 2'd0,
        MODE_COL     = 2'd1,
        MODE_ROW_ADD = 2'd2,
        MODE_INVERSE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0 = 3'd0,
        CFG_ROT_ROW1 = 3'd1,
        CFG_ROT_ROW2 = 3'd2,
        CFG_TRANS_X  = 3'd3,
        CFG_TRANS_Y  = 3'd4,
        CFG_TRANS_Z  = 3'd5
    } cfg_idx_t;

    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF   = ACC_W'(1) << (FRAC_SH - 1);

    typedef struct packed {
        logic [2:0][2:0][COEF_W-1:0] coef;
        logic [2:0][OPND_W-1:0]      opnd;
        logic [2:0][COORD_W-1:0]     bias;
    } sel_t;

    typedef struct packed {
        logic [2:0][2:0][PROD_W-1:0] prod;
        logic [2:0][COORD_W-1:0]     bias;
    } prod_stage_t;

    typedef struct packed {
        logic [2:0][ACC_W-1:0] acc;
    } acc_stage_t;

    // {clamped, value}: round half up from Q.30 to Q16.16, then clamp.
    function automatic logic [COORD_W:0] round_sat(logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0]         sum;
        logic [ACC_W-FRAC_SH-1:0] shifted;
        logic                     fits;
        sum     = acc + ROUND_HALF;
        shifted = sum[ACC_W-1:FRAC_SH];
        fits    = (shifted[ACC_W-FRAC_SH-1:COORD_W-1] == '0) ||
                  (shifted[ACC_W-FRAC_SH-1:COORD_W-1] == '1);
        if (fits)
        begin
            round_sat = {1'b0, shifted[COORD_W-1:0]};
        end
        else if (shifted[ACC_W-FRAC_SH-1])
        begin
            round_sat = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            round_sat = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

### src/rpt_select.sv
// rpt_select: stage 1, picks R or its transpose, forms operands and bias per mode.
// Depends on rpt_pkg.
module rpt_select (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [1:0]                           mode,
    input  logic signed [rpt_pkg::COORD_W-1:0]   point_x,
    input  logic signed [rpt_pkg::COORD_W-1:0]   point_y,
    input  logic signed [rpt_pkg::COORD_W-1:0]   point_z,
    input  logic [2:0][rpt_pkg::ROW_W-1:0]       rot,
    input  logic [2:0][rpt_pkg::COORD_W-1:0]     trans,
    output logic                                 valid,
    output rpt_pkg::sel_t                        data
);
    import rpt_pkg::*;

    logic  valid_reg;
    sel_t  data_reg;
    sel_t  data_next;
    mode_t mode_sel;
    logic [2:0][COORD_W-1:0] pt;

    assign mode_sel = mode_t'(mode);
    assign pt       = {point_z, point_y, point_x};

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (mode_sel == MODE_ROW || mode_sel == MODE_ROW_ADD)
                    data_next.coef[i][k] = rot[k][COEF_W*i +: COEF_W];
                else
                    data_next.coef[i][k] = rot[i][COEF_W*k +: COEF_W];
            end
            if (mode_sel == MODE_INVERSE)
                data_next.opnd[i] = {pt[i][COORD_W-1], pt[i]} -
                                    {trans[i][COORD_W-1], trans[i]};
            else
                data_next.opnd[i] = {pt[i][COORD_W-1], pt[i]};
            data_next.bias[i] = (mode_sel == MODE_ROW_ADD) ? trans[i] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

### src/rpt_multiply.sv
// rpt_multiply: stage 2, nine 16x33 signed products, registered.
// Depends on rpt_pkg.
module rpt_multiply (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  rpt_pkg::sel_t         in_data,
    output logic                  valid,
    output rpt_pkg::prod_stage_t  data
);
    import rpt_pkg::*;

    logic        valid_reg;
    prod_stage_t data_reg;
    prod_stage_t data_next;

    always_comb
    begin
        data_next      = '0;
        data_next.bias = in_data.bias;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                data_next.prod[i][k] = PROD_W'($signed(in_data.coef[i][k]) *
                                               $signed(in_data.opnd[k]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

### src/rpt_accumulate.sv
// rpt_accumulate: stage 3, three-term sums plus Q.30 translation bias.
// Depends on rpt_pkg.
module rpt_accumulate (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  rpt_pkg::prod_stage_t  in_data,
    output logic                  valid,
    output rpt_pkg::acc_stage_t   data
);
    import rpt_pkg::*;

    logic       valid_reg;
    acc_stage_t data_reg;
    acc_stage_t data_next;

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            data_next.acc[i] =
                {{(ACC_W-PROD_W){in_data.prod[i][0][PROD_W-1]}}, in_data.prod[i][0]} +
                {{(ACC_W-PROD_W){in_data.prod[i][1][PROD_W-1]}}, in_data.prod[i][1]} +
                {{(ACC_W-PROD_W){in_data.prod[i][2][PROD_W-1]}}, in_data.prod[i][2]} +
                {{(ACC_W-COORD_W-FRAC_SH){in_data.bias[i][COORD_W-1]}},
                 in_data.bias[i], {FRAC_SH{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

### src/rpt_finish.sv
// rpt_finish: stage 4, rounding, saturation and the output register.
// Depends on rpt_pkg.
module rpt_finish (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  rpt_pkg::acc_stage_t                 in_data,
    output logic                                valid,
    output logic signed [rpt_pkg::COORD_W-1:0]  result_x,
    output logic signed [rpt_pkg::COORD_W-1:0]  result_y,
    output logic signed [rpt_pkg::COORD_W-1:0]  result_z,
    output logic                                saturated
);
    import rpt_pkg::*;

    logic                    valid_reg;
    logic [2:0][COORD_W-1:0] res_reg;
    logic [2:0][COORD_W-1:0] res_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic [2:0][COORD_W:0]   rs;

    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rs[i]       = round_sat(in_data.acc[i]);
            res_next[i] = rs[i][COORD_W-1:0];
            sat_next    = sat_next | rs[i][COORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign valid     = valid_reg;
    assign result_x  = res_reg[0];
    assign result_y  = res_reg[1];
    assign result_z  = res_reg[2];
    assign saturated = sat_reg;
endmodule

### src/rigid_point_transform_top.sv
// rigid_point_transform_top: four-stage pipeline, select / multiply / sum / round.
// Throughput one point per cycle while the output is not stalled.
// The whole pipeline holds while a result waits and out_ready is low.
// Reset (async, active low) empties the pipeline, R = identity, t = 0.
// Depends on rpt_pkg, rpt_select, rpt_multiply, rpt_accumulate, rpt_finish.
module rigid_point_transform_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rpt_pkg::ROW_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            mode,
    input  logic signed [rpt_pkg::COORD_W-1:0]    point_x,
    input  logic signed [rpt_pkg::COORD_W-1:0]    point_y,
    input  logic signed [rpt_pkg::COORD_W-1:0]    point_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rpt_pkg::COORD_W-1:0]    result_x,
    output logic signed [rpt_pkg::COORD_W-1:0]    result_y,
    output logic signed [rpt_pkg::COORD_W-1:0]    result_z,
    output logic                                  saturated
);
    import rpt_pkg::*;

    logic [2:0][ROW_W-1:0]   rot_reg;
    logic [2:0][COORD_W-1:0] trans_reg;
    logic                    en;
    logic                    v1, v2, v3;
    sel_t                    d1;
    prod_stage_t             d2;
    acc_stage_t              d3;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= ROT_ROW0_RST;
            rot_reg[1] <= ROT_ROW1_RST;
            rot_reg[2] <= ROT_ROW2_RST;
            trans_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROT_ROW0: rot_reg[0]   <= cfg_data;
                CFG_ROT_ROW1: rot_reg[1]   <= cfg_data;
                CFG_ROT_ROW2: rot_reg[2]   <= cfg_data;
                CFG_TRANS_X:  trans_reg[0] <= cfg_data[COORD_W-1:0];
                CFG_TRANS_Y:  trans_reg[1] <= cfg_data[COORD_W-1:0];
                CFG_TRANS_Z:  trans_reg[2] <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    rpt_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .mode     (mode),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .rot      (rot_reg),
        .trans    (trans_reg),
        .valid    (v1),
        .data     (d1)
    );

    rpt_multiply u_multiply (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1),
        .in_data  (d1),
        .valid    (v2),
        .data     (d2)
    );

    rpt_accumulate u_accumulate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2),
        .in_data  (d2),
        .valid    (v3),
        .data     (d3)
    );

    rpt_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3),
        .in_data   (d3),
        .valid     (out_valid),
        .result_x  (result_x),
        .result_y  (result_y),
        .result_z  (result_z),
        .saturated (saturated)
    );
endmodule

### src/rpt_checker.sv
// rpt_checker: port-level assertions for rigid_point_transform_top, plus its bind.
// Depends on rpt_pkg and rigid_point_transform_top.
module rpt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [rpt_pkg::COORD_W-1:0]  result_x,
    input logic signed [rpt_pkg::COORD_W-1:0]  result_y,
    input logic signed [rpt_pkg::COORD_W-1:0]  result_z,
    input logic                                saturated
);
    import rpt_pkg::*;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_x) &&
        $stable(result_y) && $stable(result_z) && $stable(saturated))
        else $error("result changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while pipeline stalled");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline refused request with empty output");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
        result_x == SAT_MAX || result_x == SAT_MIN ||
        result_y == SAT_MAX || result_y == SAT_MIN ||
        result_z == SAT_MAX || result_z == SAT_MIN)
        else $error("saturated flag without clamped coordinate");
endmodule

bind rigid_point_transform_top rpt_checker u_rpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_x  (result_x),
    .result_y  (result_y),
    .result_z  (result_z),
    .saturated (saturated)
);
